// ===== src/nq_pkg.sv =====
// Shared constants for the n-queens first-solution search block.
package nq_pkg;

    localparam int unsigned BOARD_W       = 5;
    localparam int unsigned DEFAULT_MAX_N = 16;

endpackage

// ===== src/nq_if.sv =====
// Valid/ready stream interfaces for board-size requests and queen placements.
interface nq_req_if
    import nq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [BOARD_W-1:0] board_size;

    modport source (output valid, output board_size, input ready);
    modport sink   (input valid, input board_size, output ready);
endinterface

interface nq_rsp_if
    import nq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               found;
    logic [BOARD_W-1:0] queen_row;
    logic [BOARD_W-1:0] queen_col;
    logic               last;

    modport source (output valid, output found, output queen_row, output queen_col,
                    output last, input ready);
    modport sink   (input valid, input found, input queen_row, input queen_col,
                    input last, output ready);
endinterface

// ===== src/nq_conflict.sv =====
// Shared attack test: one earlier queen against the candidate square.
module nq_conflict
    import nq_pkg::*;
#(
    parameter int unsigned MAX_N = DEFAULT_MAX_N
) (
    input  logic [$clog2(MAX_N+1)-1:0] i_row,
    input  logic [$clog2(MAX_N)-1:0]   i_other,
    input  logic [$clog2(MAX_N+1)-1:0] i_dist,
    output logic                       o_hit
);
    localparam int unsigned CW = $clog2(MAX_N + 1);

    logic [CW-1:0] other_ext;
    logic [CW-1:0] diff;

    assign other_ext = CW'(i_other);
    assign diff      = (i_row > other_ext) ? (i_row - other_ext) : (other_ext - i_row);
    assign o_hit     = (i_row == other_ext) || (diff == i_dist);
endmodule

// ===== src/n_queens_first_solution.sv =====
// Top level: depth-first n-queens search that returns the first full placement.
// Search: each candidate square is checked against the earlier queens one at a time
// by the single attack-test unit; each try and backtrack step passes through the try state.
// Readout: each result beat is found by a scan over up to n columns; one request at a time.
// Reset: synchronous active-low clears the sequencer and the output valid; the
// placement table needs no reset since every entry is written before it is read.
module n_queens_first_solution
    import nq_pkg::*;
#(
    parameter int unsigned MAX_N = DEFAULT_MAX_N
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    nq_req_if.sink   i_req,
    nq_rsp_if.source o_rsp
);
    localparam int unsigned AW = $clog2(MAX_N);
    localparam int unsigned CW = $clog2(MAX_N + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRY,
        S_SCAN,
        S_NOSOL,
        S_OSCAN
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic [AW-1:0] r_k;
    logic [CW-1:0] r_r;
    logic [AW-1:0] r_c;

    logic [AW-1:0] r_place [MAX_N];

    logic               r_out_valid;
    logic               r_found;
    logic [BOARD_W-1:0] r_qrow;
    logic [BOARD_W-1:0] r_qcol;
    logic               r_last;

    logic [CW-1:0] size_sat;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] rd_data;
    logic [CW-1:0] col_gap;
    logic          hit;
    logic          out_fire;
    logic          in_fire;
    logic [CW-1:0] scan_row;
    logic          rsp_load;

    assign i_req.ready = (r_state == S_IDLE);
    assign in_fire     = i_req.valid && i_req.ready;
    assign out_fire    = r_out_valid && o_rsp.ready;

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.found     = r_found;
    assign o_rsp.queen_row = r_qrow;
    assign o_rsp.queen_col = r_qcol;
    assign o_rsp.last      = r_last;

    always_comb begin
        if (32'(i_req.board_size) > 32'(MAX_N)) begin
            size_sat = CW'(MAX_N);
        end else begin
            size_sat = CW'(i_req.board_size);
        end
    end

    always_comb begin
        unique case (r_state)
            S_TRY:   rd_addr = AW'(r_col - CW'(1));
            S_SCAN:  rd_addr = r_k;
            S_OSCAN: rd_addr = r_c;
            default: rd_addr = '0;
        endcase
    end

    assign rd_data  = r_place[rd_addr];
    assign col_gap  = r_col - CW'(r_k);
    assign scan_row = r_r + CW'(1);
    assign rsp_load = (!r_out_valid || out_fire)
                      && (r_state == S_NOSOL
                          || (r_state == S_OSCAN && rd_data == AW'(r_r)));

    nq_conflict #(
        .MAX_N (MAX_N)
    ) u_conflict (
        .i_row   (r_row),
        .i_other (rd_data),
        .i_dist  (col_gap),
        .o_hit   (hit)
    );

    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN && !hit && r_k == AW'(r_col - CW'(1)))
            || (r_state == S_TRY && r_col != r_n && r_row < r_n && r_col == '0)) begin
            r_place[AW'(r_col)] <= AW'(r_row);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_n         <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_k         <= '0;
            r_r         <= '0;
            r_c         <= '0;
        end else begin
            if (rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_n   <= size_sat;
                        r_col <= '0;
                        r_row <= '0;
                        r_state <= (size_sat == '0) ? S_NOSOL : S_TRY;
                    end
                end
                S_TRY: begin
                    if (r_col == r_n) begin
                        r_r     <= '0;
                        r_c     <= '0;
                        r_state <= S_OSCAN;
                    end else if (r_row >= r_n) begin
                        if (r_col == '0) begin
                            r_state <= S_NOSOL;
                        end else begin
                            r_col <= r_col - CW'(1);
                            r_row <= CW'(rd_data) + CW'(1);
                        end
                    end else if (r_col == '0) begin
                        r_col <= r_col + CW'(1);
                        r_row <= '0;
                    end else begin
                        r_k     <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_row   <= r_row + CW'(1);
                        r_state <= S_TRY;
                    end else if (r_k == AW'(r_col - CW'(1))) begin
                        r_col   <= r_col + CW'(1);
                        r_row   <= '0;
                        r_state <= S_TRY;
                    end else begin
                        r_k <= r_k + AW'(1);
                    end
                end
                S_NOSOL: begin
                    if (!r_out_valid || out_fire) begin
                        r_found     <= 1'b0;
                        r_qrow      <= '0;
                        r_qcol      <= '0;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_OSCAN: begin
                    if (rd_data == AW'(r_r)) begin
                        if (!r_out_valid || out_fire) begin
                            r_found     <= 1'b1;
                            r_qrow      <= BOARD_W'(scan_row);
                            r_qcol      <= BOARD_W'(r_c) + BOARD_W'(1);
                            r_last      <= (scan_row == r_n);
                            r_r         <= scan_row;
                            r_c         <= '0;
                            if (scan_row == r_n) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end else begin
                        r_c <= r_c + AW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== tb/n_queens_first_solution_test.sv =====
// Testbench for n_queens_first_solution: first-placement backtracking checked beat by beat.
module n_queens_first_solution_test;
    import nq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_BOARD   = DEFAULT_MAX_N;
    localparam int unsigned HOLD_CYCLES = 3000;
    localparam longint      CYCLE_LIMIT = 60_000_000;
    localparam int unsigned SETTLE      = 200;

    typedef logic [BOARD_W-1:0] t_size;

    typedef struct packed {
        logic  found;
        t_size queen_row;
        t_size queen_col;
        logic  last;
    } t_placement;

    typedef enum int unsigned {RX_ALWAYS, RX_MOSTLY, RX_PATTERN, RX_COIN} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    nq_req_if req_bus ();
    nq_rsp_if rsp_bus ();

    n_queens_first_solution #(.MAX_N(MAX_BOARD)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    t_placement  expected_placements[$];
    t_placement  head;
    int unsigned error_count  = 0;
    int unsigned boards_sent  = 0;
    int unsigned unsolvable   = 0;
    int unsigned beats_seen   = 0;
    int unsigned burst_left   = 0;
    bit          sender_gaps  = 1'b0;
    bit          hold_request = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned rx_phase     = 0;
    int unsigned rx_tick      = 0;
    t_rx_mode    rx_mode      = RX_ALWAYS;
    longint      cycle_count  = 0;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Depth-first search, one queen per column, rows tried in ascending order.
    task automatic solve_board(input t_size size);
        int  n;
        int  col;
        int  row;
        int  k;
        int  col_gap;
        int  rows[MAX_BOARD];
        bit  solved;
        bit  failed;
        bit  placed;
        bit  safe;
        t_placement beat;
        n      = (size > MAX_BOARD) ? MAX_BOARD : int'(size);
        col    = 0;
        row    = 0;
        solved = 1'b0;
        failed = (n == 0);
        while (!solved && !failed) begin
            if (col >= n) begin
                solved = 1'b1;
            end else begin
                placed = 1'b0;
                while (!placed && row < n) begin
                    safe = 1'b1;
                    for (k = 0; k < col; k++) begin
                        col_gap = col - k;
                        if (rows[k] == row || rows[k] - row == col_gap ||
                            row - rows[k] == col_gap)
                            safe = 1'b0;
                    end
                    if (safe)
                        placed = 1'b1;
                    else
                        row++;
                end
                if (placed) begin
                    rows[col] = row;
                    col++;
                    row = 0;
                end else if (col == 0) begin
                    failed = 1'b1;
                end else begin
                    col--;
                    row = rows[col] + 1;
                end
            end
        end
        if (!solved) begin
            beat = '{found: 1'b0, queen_row: '0, queen_col: '0, last: 1'b1};
            expected_placements.push_back(beat);
            unsolvable++;
        end else begin
            for (int r = 0; r < n; r++) begin
                for (int c = 0; c < n; c++) begin
                    if (rows[c] == r) begin
                        beat.found     = 1'b1;
                        beat.queen_row = t_size'(r + 1);
                        beat.queen_col = t_size'(c + 1);
                        beat.last      = (r + 1 == n);
                        expected_placements.push_back(beat);
                    end
                end
            end
        end
    endtask

    task automatic send_board(input t_size size);
        int unsigned gap;
        if (sender_gaps && burst_left == 0) begin
            gap        = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 8);
            @(negedge i_clk);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge i_clk);
        req_bus.valid      <= 1'b1;
        req_bus.board_size <= size;
        do @(posedge i_clk); while (!req_bus.ready);
        solve_board(size);
        boards_sent++;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        req_bus.valid <= 1'b0;
        while (expected_placements.size() != 0)
            @(posedge i_clk);
    endtask

    // Most random boards are cheap to search; 14 and 15 take a long time.
    function automatic t_size pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return t_size'($urandom_range(0, 3));
        else if (roll < 75)
            return t_size'($urandom_range(4, 10));
        else if (roll < 96)
            return t_size'($urandom_range(11, 13));
        else
            return t_size'($urandom_range(14, 15));
    endfunction

    task automatic test_directed();
        int sizes[$];
        sizes = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 16, 31, 18};
        sender_gaps = 1'b0;
        foreach (sizes[i])
            send_board(t_size'(sizes[i]));
        wait_for_results();
    endtask

    task automatic test_random();
        sender_gaps = 1'b1;
        repeat (95)
            send_board(pick_size());
        sender_gaps = 1'b0;
        repeat (10)
            send_board(pick_size());
        wait_for_results();
    endtask

    // Output held off while requests keep coming, so the input must stall.
    task automatic test_backpressure();
        sender_gaps  = 1'b0;
        hold_request = 1'b1;
        repeat (8)
            send_board(t_size'($urandom_range(4, 9)));
        wait_for_results();
    endtask

    task automatic test_drain_pause();
        sender_gaps = 1'b1;
        repeat (3) begin
            repeat (3)
                send_board(pick_size());
            wait_for_results();
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (rx_phase == 0) begin
            rx_mode  = t_rx_mode'($urandom_range(0, 3));
            rx_phase = $urandom_range(20, 150);
        end
        rx_phase--;
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  rsp_bus.ready <= 1'b1;
                RX_MOSTLY:  rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                RX_PATTERN: rsp_bus.ready <= (rx_tick % 7 > 2);
                default:    rsp_bus.ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            beats_seen++;
            if (expected_placements.size() == 0) begin
                error_count++;
                $display("%0t: unexpected beat found=%b row=%0d col=%0d last=%b", $time,
                         rsp_bus.found, rsp_bus.queen_row, rsp_bus.queen_col, rsp_bus.last);
            end else begin
                head = expected_placements.pop_front();
                if (rsp_bus.found !== head.found || rsp_bus.queen_row !== head.queen_row ||
                    rsp_bus.queen_col !== head.queen_col || rsp_bus.last !== head.last) begin
                    error_count++;
                    $display("%0t: mismatch expected found=%b row=%0d col=%0d last=%b",
                             $time, head.found, head.queen_row, head.queen_col, head.last);
                    $display("%0t:          actual   found=%b row=%0d col=%0d last=%b",
                             $time, rsp_bus.found, rsp_bus.queen_row, rsp_bus.queen_col,
                             rsp_bus.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats outstanding", $time,
                     expected_placements.size());
            $display("[n_queens_first_solution] ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        req_bus.valid      = 1'b0;
        req_bus.board_size = '0;
        rsp_bus.ready      = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random();
        test_backpressure();
        test_drain_pause();

        repeat (SETTLE) @(posedge i_clk);
        if (expected_placements.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected beats never arrived", $time,
                     expected_placements.size());
        end
        $display("Searched %0d board sizes (%0d with no placement), checked %0d queen beats,",
                 boards_sent, unsolvable, beats_seen);
        $display("under random bursts, output stalls and one long output hold-off.");
        if (error_count == 0) begin
            $display("[n_queens_first_solution] OK");
        end else begin
            $display("[n_queens_first_solution] ERROR");
        end
        $finish;
    end

endmodule
